FILE: hdl/lcd_gram_window_controller_unit_defines.svh
// assertion macros used by the port-level checker
`ifndef LCD_GRAM_WINDOW_CONTROLLER_UNIT_DEFINES_SVH
`define LCD_GRAM_WINDOW_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication
`define LGWC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lgwc assertion failed");

// next-cycle implication
`define LGWC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lgwc assertion failed");

`endif

FILE: hdl/lgwc_pkg.sv
// shared constants and types of the gram window controller
`default_nettype none

package lgwc_pkg;

   localparam int PANEL_COLS_DEF = 320;
   localparam int PANEL_ROWS_DEF = 240;

   localparam int DATA_W  = 16;
   localparam int INDEX_W = 8;
   localparam int TYPE_W  = 2;
   localparam int MISC_DEPTH = 256;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_INDEX = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_READ  = 2'd2;

   // register indexes
   localparam logic [INDEX_W-1:0] IDX_GRAM     = 8'h22;
   localparam logic [INDEX_W-1:0] IDX_CUR_COL  = 8'h4F;
   localparam logic [INDEX_W-1:0] IDX_CUR_ROW  = 8'h4E;
   localparam logic [INDEX_W-1:0] IDX_WCOL_BEG = 8'h45;
   localparam logic [INDEX_W-1:0] IDX_WCOL_END = 8'h46;
   localparam logic [INDEX_W-1:0] IDX_WROW     = 8'h44;

   typedef struct packed {
      logic take;
      logic calc_addr;
      logic gram_write;
      logic mem_read;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [TYPE_W-1:0] in_type;
      logic              index_is_gram;
   } status_type;

endpackage

`default_nettype wire

FILE: hdl/lgwc_req_if.sv
// request channel: bus access type and bus word
`default_nettype none

interface lgwc_req_if;
   logic                        valid;
   logic                        ready;
   logic [lgwc_pkg::TYPE_W-1:0] req_type;
   logic [lgwc_pkg::DATA_W-1:0] bus_data;

   modport source (output valid, output req_type, output bus_data, input ready);
   modport sink   (input valid, input req_type, input bus_data, output ready);
endinterface

`default_nettype wire

FILE: hdl/lgwc_rsp_if.sv
// response channel: read data
`default_nettype none

interface lgwc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lgwc_pkg::DATA_W-1:0] read_data;

   modport source (output valid, output read_data, input ready);
   modport sink   (input valid, input read_data, output ready);
endinterface

`default_nettype wire

FILE: hdl/lcd_gram_window_controller_unit.sv
// Display-controller side of a 16-bit parallel LCD bus. Each request beat is an
// index write, a data write or a data read; only reads return a response beat.
// Index writes and writes to cursor, window or plain registers are done when the beat is taken.
// A pixel write to 0x22 first registers the row*cols+col address, then does the
// frame memory write and cursor advance. A read registers the address, does a
// registered memory read, then loads the output register, which waits
// while an earlier response is still held. The plain register file keeps one
// valid bit per entry, so there is no clearing pass after reset.
`default_nettype none

module lcd_gram_window_controller_unit #(
   parameter int PANEL_COLS = lgwc_pkg::PANEL_COLS_DEF,
   parameter int PANEL_ROWS = lgwc_pkg::PANEL_ROWS_DEF
) (
   input logic         clock,
   input logic         reset,
   lgwc_req_if.sink    req_chan,
   lgwc_rsp_if.source  rsp_chan
);

   lgwc_pkg::cmd_type    cmd;
   lgwc_pkg::status_type status;

   lgwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .status    (status),
      .cmd       (cmd)
   );

   lgwc_datapath #(
      .PANEL_COLS (PANEL_COLS),
      .PANEL_ROWS (PANEL_ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_type  (req_chan.req_type),
      .bus_data  (req_chan.bus_data),
      .read_data (rsp_chan.read_data)
   );

endmodule

`default_nettype wire

FILE: hdl/lgwc_ram.sv
// generic single-write single-read ram with registered read
`default_nettype none

module lgwc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/lgwc_ctrl.sv
// sequencer for bus accesses and the response register valid
`default_nettype none

module lgwc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   input  lgwc_pkg::status_type status,
   output lgwc_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_ADDR = 4'b0010,
      S_MEM  = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rd_op_ff, rd_op_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rd_op_in     = rd_op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               case (status.in_type)
                  lgwc_pkg::REQ_WRITE: begin
                     // only pixel writes need the frame memory
                     if (status.index_is_gram) begin
                        state_in = S_ADDR;
                        rd_op_in = 1'b0;
                     end
                  end
                  lgwc_pkg::REQ_READ: begin
                     state_in = S_ADDR;
                     rd_op_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_ADDR: begin
            cmd.calc_addr = 1'b1;
            state_in      = S_MEM;
         end
         S_MEM: begin
            if (rd_op_ff) begin
               cmd.mem_read = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.gram_write = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_RESP: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_op_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_op_ff     <= rd_op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hdl/lgwc_datapath.sv
// cursor, window and index registers, frame and register memories
`default_nettype none

module lgwc_datapath #(
   parameter int PANEL_COLS = lgwc_pkg::PANEL_COLS_DEF,
   parameter int PANEL_ROWS = lgwc_pkg::PANEL_ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lgwc_pkg::cmd_type                   cmd,
   output lgwc_pkg::status_type                status,
   input  logic [lgwc_pkg::TYPE_W-1:0]         req_type,
   input  logic [lgwc_pkg::DATA_W-1:0]         bus_data,
   output logic [lgwc_pkg::DATA_W-1:0]         read_data
);

   localparam int COL_W  = $clog2(PANEL_COLS);
   localparam int ROW_W  = $clog2(PANEL_ROWS);
   localparam int DEPTH  = PANEL_COLS * PANEL_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int DW     = lgwc_pkg::DATA_W;
   localparam int IW     = lgwc_pkg::INDEX_W;
   localparam logic [COL_W-1:0] COL_MAX = COL_W'(PANEL_COLS - 1);
   localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(PANEL_ROWS - 1);

   logic [IW-1:0]     index_ff, index_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  wcs_ff, wcs_in;
   logic [COL_W-1:0]  wce_ff, wce_in;
   logic [ROW_W-1:0]  wrs_ff, wrs_in;
   logic [ROW_W-1:0]  wre_ff, wre_in;
   logic [lgwc_pkg::MISC_DEPTH-1:0] misc_vld_ff;
   logic [DW-1:0]     data_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [DW-1:0]     rsp_data_ff;

   logic [COL_W-1:0]  col_sat;
   logic [ROW_W-1:0]  row_sat;
   logic [ROW_W-1:0]  row_hi_sat;
   logic [ROW_W-1:0]  row_lo_sat;
   logic              wr_reg;
   logic              wr_misc;
   logic [DW-1:0]     frame_q;
   logic [DW-1:0]     misc_q;
   logic [DW-1:0]     rd_sel;

   always_comb begin
      col_sat    = (bus_data > DW'(PANEL_COLS - 1)) ? COL_MAX : bus_data[COL_W-1:0];
      row_sat    = (bus_data > DW'(PANEL_ROWS - 1)) ? ROW_MAX : bus_data[ROW_W-1:0];
      row_hi_sat = (bus_data[15:8] > 8'(PANEL_ROWS - 1)) ? ROW_MAX : bus_data[ROW_W+7:8];
      row_lo_sat = (bus_data[7:0] > 8'(PANEL_ROWS - 1)) ? ROW_MAX : bus_data[ROW_W-1:0];
   end

   assign wr_reg  = cmd.take && (req_type == lgwc_pkg::REQ_WRITE);
   assign wr_misc = wr_reg && !(index_ff inside {lgwc_pkg::IDX_GRAM, lgwc_pkg::IDX_CUR_COL,
                                                 lgwc_pkg::IDX_CUR_ROW, lgwc_pkg::IDX_WCOL_BEG,
                                                 lgwc_pkg::IDX_WCOL_END, lgwc_pkg::IDX_WROW});

   always_comb begin
      index_in = index_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      wcs_in   = wcs_ff;
      wce_in   = wce_ff;
      wrs_in   = wrs_ff;
      wre_in   = wre_ff;
      if (cmd.take && (req_type == lgwc_pkg::REQ_INDEX)) begin
         index_in = bus_data[IW-1:0];
      end
      if (wr_reg) begin
         case (index_ff)
            lgwc_pkg::IDX_CUR_COL:  col_in = col_sat;
            lgwc_pkg::IDX_CUR_ROW:  row_in = row_sat;
            lgwc_pkg::IDX_WCOL_BEG: wcs_in = col_sat;
            lgwc_pkg::IDX_WCOL_END: wce_in = col_sat;
            lgwc_pkg::IDX_WROW: begin
               wre_in = row_hi_sat;
               wrs_in = row_lo_sat;
            end
            default: ;
         endcase
      end
      if (cmd.gram_write) begin
         // wrap at the window's right edge, then at its bottom
         if (col_ff >= wce_ff) begin
            col_in = wcs_ff;
            row_in = (row_ff >= wre_ff) ? wrs_ff : ROW_W'(row_ff + 1'b1);
         end else begin
            col_in = COL_W'(col_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff    <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         wcs_ff      <= '0;
         wce_ff      <= COL_MAX;
         wrs_ff      <= '0;
         wre_ff      <= ROW_MAX;
         misc_vld_ff <= '0;
      end else begin
         index_ff <= index_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         wcs_ff   <= wcs_in;
         wce_ff   <= wce_in;
         wrs_ff   <= wrs_in;
         wre_ff   <= wre_in;
         if (wr_misc) begin
            misc_vld_ff[index_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         data_ff <= bus_data;
      end
      if (cmd.calc_addr) begin
         addr_ff <= ADDR_W'(row_ff) * ADDR_W'(PANEL_COLS) + ADDR_W'(col_ff);
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= rd_sel;
      end
   end

   lgwc_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (cmd.gram_write),
      .wr_addr (addr_ff),
      .wr_data (data_ff),
      .rd_en   (cmd.mem_read),
      .rd_addr (addr_ff),
      .rd_data (frame_q)
   );

   lgwc_ram #(
      .WIDTH (DW),
      .DEPTH (lgwc_pkg::MISC_DEPTH)
   ) u_misc_ram (
      .clock   (clock),
      .wr_en   (wr_misc),
      .wr_addr (index_ff),
      .wr_data (bus_data),
      .rd_en   (cmd.mem_read),
      .rd_addr (index_ff),
      .rd_data (misc_q)
   );

   always_comb begin
      case (index_ff)
         lgwc_pkg::IDX_CUR_COL:  rd_sel = DW'(col_ff);
         lgwc_pkg::IDX_CUR_ROW:  rd_sel = DW'(row_ff);
         lgwc_pkg::IDX_WCOL_BEG: rd_sel = DW'(wcs_ff);
         lgwc_pkg::IDX_WCOL_END: rd_sel = DW'(wce_ff);
         lgwc_pkg::IDX_WROW:     rd_sel = {8'(wre_ff), 8'(wrs_ff)};
         lgwc_pkg::IDX_GRAM:     rd_sel = frame_q;
         // never-written register reads as zero
         default:                rd_sel = misc_vld_ff[index_ff] ? misc_q : '0;
      endcase
   end

   assign status.in_type       = req_type;
   assign status.index_is_gram = (index_ff == lgwc_pkg::IDX_GRAM);
   assign read_data            = rsp_data_ff;

endmodule

`default_nettype wire

FILE: hdl/lgwc_checker.sv
// port-level checks of the gram window controller and their bind
`default_nettype none
`include "lcd_gram_window_controller_unit_defines.svh"

module lgwc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [lgwc_pkg::TYPE_W-1:0] req_type,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [lgwc_pkg::DATA_W-1:0] rsp_data
);

   logic take_read;
   logic take_index;

   assign take_read  = req_valid && req_ready && (req_type == lgwc_pkg::REQ_READ);
   assign take_index = req_valid && req_ready && (req_type == lgwc_pkg::REQ_INDEX);

   // a read beat holds off the next request while it is worked on
   `LGWC_ASSERT_NEXT(a_read_blocks, clock, reset, take_read, !req_ready)

   // an index write leaves the block ready for the next beat
   `LGWC_ASSERT_NEXT(a_index_fast, clock, reset, take_index, req_ready)

   // a new response only comes out of the response phase
   `LGWC_ASSERT_NOW(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(!req_ready))

   // a stalled response holds its data
   `LGWC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind lcd_gram_window_controller_unit lgwc_checker u_lgwc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_type  (req_chan.req_type),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.read_data)
);

`default_nettype wire

FILE: dv/lgwc_tb_pkg.sv
// panel geometry and cursor/window rules shared by the gram stimulus and checker
package lgwc_tb_pkg;
   import lgwc_pkg::*;

   localparam int COLS   = PANEL_COLS_DEF;
   localparam int ROWS   = PANEL_ROWS_DEF;
   localparam int PIXELS = COLS * ROWS;

   // request code the block must drop without a response
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [8:0]         col;
      logic [7:0]         row;
      logic [8:0]         col_beg;
      logic [8:0]         col_end;
      logic [7:0]         row_beg;
      logic [7:0]         row_end;
   } gram_view_type;

   function automatic gram_view_type view_after_reset();
      gram_view_type v;
      v         = '0;
      v.col_end = 9'(COLS - 1);
      v.row_end = 8'(ROWS - 1);
      return v;
   endfunction

   function automatic logic [8:0] clip_col(logic [DATA_W-1:0] v);
      return (v > COLS - 1) ? 9'(COLS - 1) : v[8:0];
   endfunction

   function automatic logic [7:0] clip_row(logic [DATA_W-1:0] v);
      return (v > ROWS - 1) ? 8'(ROWS - 1) : v[7:0];
   endfunction

   function automatic int cursor_offset(gram_view_type v);
      return int'(v.row) * COLS + int'(v.col);
   endfunction

   // cursor and window registers after a data beat under the current index
   function automatic gram_view_type after_data_write(gram_view_type v, logic [DATA_W-1:0] d);
      case (v.index)
         IDX_CUR_COL:  v.col     = clip_col(d);
         IDX_CUR_ROW:  v.row     = clip_row(d);
         IDX_WCOL_BEG: v.col_beg = clip_col(d);
         IDX_WCOL_END: v.col_end = clip_col(d);
         IDX_WROW: begin
            v.row_end = clip_row({8'h00, d[15:8]});
            v.row_beg = clip_row({8'h00, d[7:0]});
         end
         IDX_GRAM: begin
            // wrap to window start at or past the end; inverted window pins the cursor
            if (v.col >= v.col_end) begin
               v.col = v.col_beg;
               v.row = (v.row >= v.row_end) ? v.row_beg : v.row + 8'd1;
            end else begin
               v.col = v.col + 9'd1;
            end
         end
         default: ;
      endcase
      return v;
   endfunction

endpackage

FILE: dv/lgwc_checker.sv
// predicts read data of the gram window controller and compares response beats
module lgwc_tb_checker (
   input  logic        clock,
   input  logic        reset,
   lgwc_req_if         req_chan,
   lgwc_rsp_if         rsp_chan,
   output int unsigned fail_count,
   output int unsigned reads_pending
);
   import lgwc_pkg::*;
   import lgwc_tb_pkg::*;

   gram_view_type     view;
   logic [DATA_W-1:0] plain_regs [MISC_DEPTH];
   logic [DATA_W-1:0] frame_mem [PIXELS];
   logic [DATA_W-1:0] expected_read_q [$];

   function automatic logic [DATA_W-1:0] predict_read_value();
      case (view.index)
         IDX_CUR_COL:  return {7'd0, view.col};
         IDX_CUR_ROW:  return {8'd0, view.row};
         IDX_WCOL_BEG: return {7'd0, view.col_beg};
         IDX_WCOL_END: return {7'd0, view.col_end};
         IDX_WROW:     return {view.row_end, view.row_beg};
         IDX_GRAM:     return frame_mem[cursor_offset(view)];
         default:      return plain_regs[view.index];
      endcase
   endfunction

   always @(posedge clock) begin
      logic [DATA_W-1:0] word;
      if (reset) begin
         view = view_after_reset();
         for (int i = 0; i < MISC_DEPTH; i++) plain_regs[i] = '0;
         expected_read_q.delete();
         fail_count    <= 0;
         reads_pending <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_read_q.size() == 0) begin
               $display("%0t: read_data expected none, got %h", $time, rsp_chan.read_data);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_chan.read_data !== expected_read_q[0]) begin
                  $display("%0t: read_data expected %h, got %h",
                           $time, expected_read_q[0], rsp_chan.read_data);
                  fail_count <= fail_count + 1;
               end
               void'(expected_read_q.pop_front());
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            word = req_chan.bus_data;
            case (req_chan.req_type)
               REQ_INDEX: view.index = word[INDEX_W-1:0];
               REQ_WRITE: begin
                  case (view.index)
                     IDX_GRAM: frame_mem[cursor_offset(view)] = word;
                     IDX_CUR_COL, IDX_CUR_ROW, IDX_WCOL_BEG, IDX_WCOL_END, IDX_WROW: ;
                     default: plain_regs[view.index] = word;
                  endcase
                  view = after_data_write(view, word);
               end
               REQ_READ: expected_read_q.push_back(predict_read_value());
               default: ;
            endcase
         end
         reads_pending <= expected_read_q.size();
      end
   end

endmodule

FILE: dv/tb_top.sv
// stimulus and verdict for the gram window controller
module tb_top;
   import lgwc_pkg::*;
   import lgwc_tb_pkg::*;

   localparam int BEATS_TOTAL = 1650;
   localparam logic [INDEX_W-1:0] PLAIN_TOP = 8'hFF;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned reads_pending;

   // stimulus-side copy of the cursor, only to keep reads off unwritten pixels
   gram_view_type shadow;
   bit          pixel_written [PIXELS];
   int          written_q [$];
   int unsigned beats_sent;
   int unsigned burst_left;

   lgwc_req_if req_chan ();
   lgwc_rsp_if rsp_chan ();

   lcd_gram_window_controller_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   lgwc_tb_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .reads_pending (reads_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver: quiet, light, busy and long-stall phases in turn, picked by cycle_no[9:8]
   initial begin
      int unsigned cycle_no;
      int unsigned stall_left;
      int unsigned len;
      cycle_no   = 0;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cycle_no++;
         if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            len = 0;
            case (cycle_no[9:8])
               2'd1: if ($urandom_range(3) == 0) len = $urandom_range(3, 1);
               2'd2: if ($urandom_range(1) == 0) len = $urandom_range(8, 1);
               2'd3: if ($urandom_range(15) == 0) len = $urandom_range(40, 10);
               default: ;
            endcase
            rsp_chan.ready <= (len == 0);
            if (len != 0) stall_left = len - 1;
         end
      end
   end

   task automatic issue(input logic [TYPE_W-1:0] kind, input logic [DATA_W-1:0] word);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(40, 1);
         if ($urandom_range(3) == 0) gap = 0;
         else if ($urandom_range(7) == 0) gap = $urandom_range(25, 8);
         else gap = $urandom_range(4, 1);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.bus_data <= word;
      do @(posedge clock); while (!req_chan.ready);
      beats_sent++;
      case (kind)
         REQ_INDEX: shadow.index = word[INDEX_W-1:0];
         REQ_WRITE: begin
            if (shadow.index == IDX_GRAM) begin
               pixel_written[cursor_offset(shadow)] = 1'b1;
               written_q.push_back(cursor_offset(shadow));
               if (written_q.size() > 64) void'(written_q.pop_front());
            end
            shadow = after_data_write(shadow, word);
         end
         default: ;
      endcase
   endtask

   task automatic read_now();
      if (shadow.index != IDX_GRAM || pixel_written[cursor_offset(shadow)])
         issue(REQ_READ, 16'($urandom));
   endtask

   task automatic set_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] word);
      issue(REQ_INDEX, {8'($urandom), idx});
      issue(REQ_WRITE, word);
   endtask

   // program a window and cursor, then stream pixels into it
   task automatic fill_window();
      logic [DATA_W-1:0] col_lo;
      logic [DATA_W-1:0] col_hi;
      logic [DATA_W-1:0] row_lo;
      logic [DATA_W-1:0] row_hi;
      int unsigned       n;
      col_lo = 16'($urandom_range(COLS - 1));
      row_lo = 16'($urandom_range(ROWS - 1));
      col_hi = col_lo + 16'($urandom_range(7));
      row_hi = row_lo + 16'($urandom_range(3));
      case ($urandom_range(7))
         0: begin
            col_lo = '0;
            row_lo = '0;
            col_hi = 16'hFFFF;
            row_hi = 16'h00FF;
         end
         1: begin
            // often inverted
            col_hi = 16'($urandom_range(COLS - 1));
            row_hi = 16'($urandom_range(ROWS - 1));
         end
         default: ;
      endcase
      set_reg(IDX_WCOL_BEG, col_lo);
      set_reg(IDX_WCOL_END, col_hi);
      set_reg(IDX_WROW, {row_hi[7:0], row_lo[7:0]});
      if ($urandom_range(3) != 0) begin
         set_reg(IDX_CUR_COL, col_lo);
         set_reg(IDX_CUR_ROW, row_lo);
      end else begin
         set_reg(IDX_CUR_COL, ($urandom_range(1) != 0) ? 16'($urandom)
                                                        : 16'($urandom_range(COLS - 1)));
         set_reg(IDX_CUR_ROW, ($urandom_range(1) != 0) ? 16'($urandom)
                                                        : 16'($urandom_range(ROWS - 1)));
      end
      issue(REQ_INDEX, {8'($urandom), IDX_GRAM});
      n = $urandom_range(24, 1);
      repeat (n) begin
         issue(REQ_WRITE, 16'($urandom));
         if ($urandom_range(5) == 0) read_now();
      end
   endtask

   task automatic readback_pixels();
      int off;
      repeat ($urandom_range(4, 1)) begin
         if (written_q.size() != 0) begin
            off = written_q[$urandom_range(written_q.size() - 1)];
            set_reg(IDX_CUR_COL, 16'(off % COLS));
            set_reg(IDX_CUR_ROW, 16'(off / COLS));
            issue(REQ_INDEX, {8'($urandom), IDX_GRAM});
            read_now();
            // a read must not move the cursor
            if ($urandom_range(1) == 0) read_now();
         end
      end
   endtask

   task automatic plain_reg_pass();
      logic [INDEX_W-1:0] idx;
      idx = 8'($urandom);
      set_reg(idx, 16'($urandom));
      read_now();
      if ($urandom_range(1) == 0) begin
         issue(REQ_INDEX, 16'($urandom));
         read_now();
      end
   endtask

   task automatic window_reg_pass();
      logic [INDEX_W-1:0] idx;
      case ($urandom_range(5))
         0:       idx = IDX_CUR_COL;
         1:       idx = IDX_CUR_ROW;
         2:       idx = IDX_WCOL_BEG;
         3:       idx = IDX_WCOL_END;
         4:       idx = IDX_WROW;
         default: idx = IDX_GRAM;
      endcase
      issue(REQ_INDEX, {8'($urandom), idx});
      read_now();
      if ($urandom_range(1) == 0) begin
         issue(REQ_WRITE, 16'($urandom));
         read_now();
      end
   endtask

   task automatic noise();
      logic [TYPE_W-1:0] kind;
      repeat ($urandom_range(8, 1)) begin
         kind = 2'($urandom_range(3));
         if (kind == REQ_READ) read_now();
         else issue(kind, 16'($urandom));
      end
   endtask

   initial begin
      bit          drained_once;
      int unsigned wait_cycles;
      drained_once      = 1'b0;
      beats_sent        = 0;
      burst_left        = 0;
      shadow            = view_after_reset();
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.req_type <= REQ_INDEX;
      req_chan.bus_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: saturation, wide index, wrap at the panel corner, readbacks
      issue(REQ_READ, 16'h0000);
      issue(REQ_UNUSED, 16'hFFFF);
      issue(REQ_INDEX, {8'hFF, IDX_CUR_COL});
      issue(REQ_WRITE, 16'hFFFF);
      issue(REQ_INDEX, {8'h00, IDX_CUR_ROW});
      issue(REQ_WRITE, 16'hFFFF);
      issue(REQ_INDEX, {8'hA5, IDX_WROW});
      issue(REQ_WRITE, 16'hFFEE);
      issue(REQ_INDEX, {8'h5A, IDX_WCOL_BEG});
      issue(REQ_WRITE, 16'h013E);
      issue(REQ_INDEX, {8'h00, IDX_WCOL_END});
      issue(REQ_WRITE, 16'h013F);
      issue(REQ_INDEX, {8'h80, IDX_GRAM});
      issue(REQ_WRITE, 16'hFFFF);
      issue(REQ_WRITE, 16'h0000);
      issue(REQ_WRITE, 16'h8001);
      issue(REQ_WRITE, 16'h7FFE);
      read_now();
      issue(REQ_INDEX, {8'h00, IDX_WROW});
      read_now();
      issue(REQ_INDEX, {8'hFF, IDX_CUR_COL});
      read_now();
      issue(REQ_INDEX, {8'h00, PLAIN_TOP});
      issue(REQ_WRITE, 16'hFFFF);
      read_now();

      while (beats_sent < BEATS_TOTAL) begin
         if (!drained_once && beats_sent >= BEATS_TOTAL / 2) begin
            drained_once = 1'b1;
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (reads_pending != 0);
         end
         case ($urandom_range(9))
            0, 1, 2, 3: fill_window();
            4, 5:       readback_pixels();
            6:          plain_reg_pass();
            7:          window_reg_pass();
            default:    noise();
         endcase
      end

      req_chan.valid <= 1'b0;
      wait_cycles = 0;
      do begin
         @(posedge clock);
         wait_cycles++;
      end while (reads_pending != 0 && wait_cycles < 20000);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && reads_pending == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #2500000;
      $display("tb_top failed");
      $finish;
   end

endmodule
